@@ hdl/kti_pkg.sv @@
// Shared constants and types for the keyed table linear interpolator.
`timescale 1ns / 1ps
package kti_pkg;
  localparam int TABLE_ROWS = 256;
  localparam int NUM_MOMENTS = 5;
  localparam int ROW_W = $clog2(TABLE_ROWS);
  localparam int CNT_W = $clog2(TABLE_ROWS + 1);
  localparam int VAL_DEPTH = TABLE_ROWS * NUM_MOMENTS;
  localparam int VAL_AW = $clog2(VAL_DEPTH);
  localparam int KEY_W = 40;
  localparam int EN_W = 24;
  localparam int MOM_W = 32;
  localparam int FRAC_W = 17;
  localparam int NUM_W = EN_W + 17;

  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_APPEND = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_SMALL = 3'd1;
  localparam logic [2:0] ST_LARGE = 3'd2;
  localparam logic [2:0] ST_NONE = 3'd3;
  localparam logic [2:0] ST_FULL = 3'd4;

  localparam logic [FRAC_W-1:0] FRAC_ONE = FRAC_W'(65536);

  typedef logic signed [MOM_W-1:0] moment_t;
endpackage

@@ hdl/kti_ram.sv @@
// Generic simple dual-port RAM with a registered read.
`timescale 1ns / 1ps
module kti_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ hdl/kti_div.sv @@
// Restoring divider, one quotient bit per cycle, for the interpolation fraction.
`timescale 1ns / 1ps
module kti_div import kti_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [NUM_W-1:0]  num,
  input  logic [EN_W-1:0]   den,
  output logic              done,
  output logic [FRAC_W-1:0] quot
);
  localparam int STEP_W = $clog2(NUM_W + 1);

  logic              busy;
  logic [STEP_W-1:0] steps;
  logic [NUM_W-1:0]  nsh;
  logic [EN_W-1:0]   rem;
  logic [EN_W-1:0]   dvs;
  logic [EN_W:0]     trial;
  logic              qbit;

  always_comb begin
    trial = {rem, nsh[NUM_W-1]};
    qbit = (trial >= {1'b0, dvs});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        steps <= '0;
        nsh <= num;
        dvs <= den;
        rem <= '0;
        quot <= '0;
      end else if (busy) begin
        nsh <= {nsh[NUM_W-2:0], 1'b0};
        rem <= qbit ? EN_W'(trial - {1'b0, dvs}) : trial[EN_W-1:0];
        quot <= {quot[FRAC_W-2:0], qbit};
        steps <= steps + 1'b1;
        if (steps == STEP_W'(NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

@@ hdl/keyed_table_linear_interpolator.sv @@
// Top level of the keyed table linear interpolator.
`timescale 1ns / 1ps
// The block keeps a table of up to TABLE_ROWS rows, each a material code, an element code,
// a Q16.8 energy and five signed Q16.16 moments, held in two synchronous RAMs (keys and
// moments). One transaction is handled at a time and yields exactly one result transaction.
// An append writes the five moments one at a time through the single write port of the
// moment RAM. A query walks the key RAM one row per cycle to settle its status; an
// interpolating query then runs the bit-serial divider that forms the Q1.16 fraction and
// reads and blends the five moments one after another through one multiplier. Rows are
// never cleared in memory; only the row count is reset, and no row at or beyond it is used.
module keyed_table_linear_interpolator import kti_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         cmd,
  input  logic [7:0]         material_id,
  input  logic [7:0]         element_id,
  input  logic [EN_W-1:0]    energy,
  input  logic signed [31:0] range_in,
  input  logic signed [31:0] sigma_in,
  input  logic signed [31:0] skew_in,
  input  logic signed [31:0] kurtosis_in,
  input  logic signed [31:0] lateral_in,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         status,
  output logic signed [31:0] range_out,
  output logic signed [31:0] sigma_out,
  output logic signed [31:0] skew_out,
  output logic signed [31:0] kurtosis_out,
  output logic signed [31:0] lateral_out
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_APP = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_DIV = 3'd3;
  localparam logic [2:0] S_BLEND = 3'd4;
  localparam logic [2:0] S_OUT = 3'd5;

  logic [2:0] state;
  logic [CNT_W-1:0] row_count;

  // Captured transaction.
  logic [7:0]      q_mat;
  logic [7:0]      q_elem;
  logic [EN_W-1:0] q_en;
  moment_t         q_mom [NUM_MOMENTS];

  // Scan bookkeeping.
  logic [CNT_W-1:0] iss;
  logic             chk_v;
  logic [ROW_W-1:0] chk_idx;
  logic             seen;
  logic [ROW_W-1:0] prev_row;
  logic [ROW_W-1:0] hit_row;
  logic [EN_W-1:0]  e0;

  // Blend sequencing.
  logic [2:0] mom_k;
  logic [2:0] phase;
  logic [FRAC_W-1:0] frac;
  moment_t v0;
  logic signed [MOM_W:0] delta;
  logic signed [MOM_W+FRAC_W+1:0] prod;
  moment_t res [NUM_MOMENTS];
  logic [2:0] st_res;

  // RAM ports.
  logic              key_we;
  logic [ROW_W-1:0]  key_waddr;
  logic [KEY_W-1:0]  key_wdata;
  logic [ROW_W-1:0]  key_raddr;
  logic [KEY_W-1:0]  key_rdata;
  logic              val_we;
  logic [VAL_AW-1:0] val_waddr;
  logic [VAL_AW-1:0] val_raddr;
  logic [MOM_W-1:0]  val_rdata;

  // Divider.
  logic              div_start;
  logic              div_done;
  logic [FRAC_W-1:0] div_quot;
  logic [EN_W-1:0]   div_den;
  logic [NUM_W-1:0]  div_num;

  logic in_acc;
  logic [7:0] k_mat;
  logic [7:0] k_elem;
  logic [EN_W-1:0] k_en;
  logic k_match;
  logic [ROW_W-1:0] vrow;
  logic signed [MOM_W+FRAC_W+1:0] sum;

  assign in_stall = (state != S_IDLE);
  assign in_acc = in_valid && !in_stall;
  assign out_valid = (state == S_OUT);

  assign k_mat = key_rdata[39:32];
  assign k_elem = key_rdata[31:24];
  assign k_en = key_rdata[EN_W-1:0];
  assign k_match = (k_mat == q_mat) && (k_elem == q_elem);

  // The key is written at the first step of an append, the moments one per step.
  assign key_we = (state == S_APP) && (mom_k == 3'd0);
  assign key_waddr = row_count[ROW_W-1:0];
  assign key_wdata = {q_mat, q_elem, q_en};
  assign key_raddr = iss[ROW_W-1:0];
  assign val_we = (state == S_APP);
  assign val_waddr = VAL_AW'({row_count[ROW_W-1:0], 2'b00}) + VAL_AW'(row_count[ROW_W-1:0])
                     + VAL_AW'(mom_k);
  assign vrow = (phase == 3'd0) ? prev_row : hit_row;
  assign val_raddr = VAL_AW'({vrow, 2'b00}) + VAL_AW'(vrow) + VAL_AW'(mom_k);

  // The fraction numerator carries half the span so the quotient rounds to nearest.
  assign div_den = k_en - e0;
  assign div_num = {1'b0, q_en - e0, 16'b0} + NUM_W'(div_den[EN_W-1:1]);

  // Blend as v0 + (v1 - v0) * f, rounded half up, on a 16 bit fractional sum.
  assign sum = {{(FRAC_W-16+2){v0[MOM_W-1]}}, v0, 16'b0} + prod
               + (MOM_W+FRAC_W+2)'(32768);

  always_comb begin
    div_start = 1'b0;
    if (state == S_SCAN && chk_v && k_match && !(!seen && q_en < k_en) && q_en <= k_en
        && q_en != k_en) begin
      div_start = 1'b1;
    end
  end

  kti_ram #(.WIDTH(KEY_W), .DEPTH(TABLE_ROWS)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (key_waddr),
    .wdata (key_wdata),
    .raddr (key_raddr),
    .rdata (key_rdata)
  );

  kti_ram #(.WIDTH(MOM_W), .DEPTH(VAL_DEPTH)) u_val_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (val_waddr),
    .wdata (q_mom[mom_k]),
    .raddr (val_raddr),
    .rdata (val_rdata)
  );

  kti_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_ff @(posedge clk) begin
    if (in_acc) begin
      q_mat <= material_id;
      q_elem <= element_id;
      q_en <= energy;
      q_mom[0] <= range_in;
      q_mom[1] <= sigma_in;
      q_mom[2] <= skew_in;
      q_mom[3] <= kurtosis_in;
      q_mom[4] <= lateral_in;
      for (int i = 0; i < NUM_MOMENTS; i++) begin
        res[i] <= '0;
      end
    end
    if (state == S_BLEND) begin
      case (phase)
        3'd1: v0 <= val_rdata;
        3'd2: delta <= {val_rdata[MOM_W-1], val_rdata} - {v0[MOM_W-1], v0};
        3'd3: prod <= (MOM_W+FRAC_W+2)'(delta * $signed({1'b0, frac}));
        3'd4: res[mom_k] <= sum[MOM_W+15:16];
        default: ;
      endcase
    end
    if (state == S_SCAN && chk_v && k_match && !(!seen && q_en < k_en)) begin
      if (q_en <= k_en) begin
        hit_row <= chk_idx;
        if (q_en == k_en) begin
          prev_row <= chk_idx;
        end
      end else begin
        prev_row <= chk_idx;
        e0 <= k_en;
      end
    end
    if (div_done) begin
      frac <= (div_quot > FRAC_ONE) ? FRAC_ONE : div_quot;
    end else if (state == S_SCAN) begin
      frac <= FRAC_ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      row_count <= '0;
      st_res <= ST_OK;
      iss <= '0;
      chk_v <= 1'b0;
      chk_idx <= '0;
      seen <= 1'b0;
      mom_k <= '0;
      phase <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            st_res <= ST_OK;
            mom_k <= '0;
            phase <= '0;
            iss <= '0;
            chk_v <= 1'b0;
            seen <= 1'b0;
            case (cmd)
              CMD_CLEAR: begin
                row_count <= '0;
                state <= S_OUT;
              end
              CMD_APPEND: begin
                if (row_count == CNT_W'(TABLE_ROWS)) begin
                  st_res <= ST_FULL;
                  state <= S_OUT;
                end else begin
                  state <= S_APP;
                end
              end
              CMD_QUERY: begin
                if (row_count == '0) begin
                  st_res <= ST_NONE;
                  state <= S_OUT;
                end else begin
                  state <= S_SCAN;
                end
              end
              default: state <= S_OUT;
            endcase
          end
        end
        S_APP: begin
          mom_k <= mom_k + 3'd1;
          if (mom_k == 3'(NUM_MOMENTS - 1)) begin
            row_count <= row_count + 1'b1;
            state <= S_OUT;
          end
        end
        S_SCAN: begin
          // One row address goes out each cycle; its key is judged in the next cycle.
          chk_v <= (iss < row_count);
          chk_idx <= iss[ROW_W-1:0];
          if (iss < row_count) begin
            iss <= iss + 1'b1;
          end
          if (chk_v) begin
            if (k_match) begin
              if (!seen && q_en < k_en) begin
                st_res <= ST_SMALL;
                state <= S_OUT;
              end else if (q_en <= k_en) begin
                state <= (q_en == k_en) ? S_BLEND : S_DIV;
              end else begin
                seen <= 1'b1;
                if (CNT_W'(chk_idx) + 1'b1 == row_count) begin
                  st_res <= ST_NONE;
                  state <= S_OUT;
                end
              end
            end else if (seen) begin
              st_res <= ST_LARGE;
              state <= S_OUT;
            end else if (CNT_W'(chk_idx) + 1'b1 == row_count) begin
              st_res <= ST_NONE;
              state <= S_OUT;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_BLEND;
          end
        end
        S_BLEND: begin
          if (phase == 3'd4) begin
            phase <= '0;
            mom_k <= mom_k + 3'd1;
            if (mom_k == 3'(NUM_MOMENTS - 1)) begin
              state <= S_OUT;
            end
          end else begin
            phase <= phase + 3'd1;
          end
        end
        S_OUT: begin
          if (!out_stall) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign status = st_res;
  assign range_out = res[0];
  assign sigma_out = res[1];
  assign skew_out = res[2];
  assign kurtosis_out = res[3];
  assign lateral_out = res[4];

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    row_count <= CNT_W'(TABLE_ROWS))
    else $error("row count beyond table size");
  a_div_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV)
    else $error("divider finished outside the divide state");
  a_append_grows: assert property (@(posedge clk) disable iff (rst)
    (state == S_APP && mom_k == 3'(NUM_MOMENTS - 1)) |=> row_count == $past(row_count) + 1'b1)
    else $error("append did not add a row");
  a_ok_on_blend: assert property (@(posedge clk) disable iff (rst)
    (state == S_BLEND) |-> st_res == ST_OK)
    else $error("blending with a failure status");
`endif
endmodule
